### hw/rtl/pbsl_pkg.sv
`timescale 1ns / 1ps

package pbsl_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;
    localparam int COORD_BITS       = 16;
    localparam int COUNT_W          = 10;
    localparam int LEVEL_W          = 7;
    localparam int FRAC_SHIFT       = 16;
    localparam int X_W              = COORD_BITS + FRAC_SHIFT + 4;
    localparam int Z_W              = 26;
    localparam int BEAR_W           = Z_W - 8;
    localparam int ATAN_W           = 22;
    localparam int ATAN_IDX_W       = 5;
    localparam int TABLE_LEN        = 101;
    localparam int POS_W            = 7;
    localparam int SRCH_STEPS       = POS_W;
    localparam int BIT_W            = 3;
    localparam int S_TDATA_W        = 48;
    localparam int M_TDATA_W        = 8;

    localparam logic [COUNT_W-1:0]       MIN_POINTS_RST = 10'd4;
    localparam logic signed [Z_W-1:0]    Z_QUARTER      = 26'sd5898240;
    localparam logic signed [Z_W-1:0]    Z_ROUND        = 26'sd128;
    localparam logic signed [BEAR_W-1:0] THR_FLOOR      = 18'sh20000;
    localparam logic [POS_W-1:0]         POS_MAX        = 7'd100;
    localparam logic signed [LEVEL_W:0]  LEVEL_OFS      = 8'sd50;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_BEARING,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic rotate;
        logic bearing;
        logic search;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic upd_now;
        logic rot_last;
        logic srch_last;
    } stat_t;

    // bearing thresholds in 1/256 degree, descending
    localparam logic signed [BEAR_W-1:0] THR_Q8 [TABLE_LEN] = '{
        18'sd6400, 18'sd6298, 18'sd6195, 18'sd6093, 18'sd5990,
        18'sd5888, 18'sd5786, 18'sd5683, 18'sd5581, 18'sd5478,
        18'sd5376, 18'sd5274, 18'sd5171, 18'sd5069, 18'sd4966,
        18'sd4864, 18'sd4762, 18'sd4659, 18'sd4557, 18'sd4454,
        18'sd4352, 18'sd4224, 18'sd4096, 18'sd3968, 18'sd3840,
        18'sd3712, 18'sd3584, 18'sd3456, 18'sd3328, 18'sd3200,
        18'sd3072, 18'sd2995, 18'sd2918, 18'sd2842, 18'sd2765,
        18'sd2688, 18'sd2611, 18'sd2534, 18'sd2458, 18'sd2381,
        18'sd2304, 18'sd2227, 18'sd2150, 18'sd2074, 18'sd1997,
        18'sd1920, 18'sd1843, 18'sd1766, 18'sd1690, 18'sd1613,
        18'sd1536, 18'sd1331, 18'sd1126, 18'sd922, 18'sd717,
        18'sd512, 18'sd307, 18'sd102, -18'sd102, -18'sd307,
        -18'sd512, -18'sd589, -18'sd666, -18'sd742, -18'sd819,
        -18'sd896, -18'sd973, -18'sd1050, -18'sd1126, -18'sd1203,
        -18'sd1280, -18'sd1382, -18'sd1485, -18'sd1587, -18'sd1690,
        -18'sd1792, -18'sd1894, -18'sd1997, -18'sd2099, -18'sd2202,
        -18'sd2304, -18'sd2406, -18'sd2509, -18'sd2611, -18'sd2714,
        -18'sd2816, -18'sd2918, -18'sd3021, -18'sd3123, -18'sd3226,
        -18'sd3328, -18'sd3456, -18'sd3584, -18'sd3712, -18'sd3840,
        -18'sd3968, -18'sd4096, -18'sd4224, -18'sd4352, -18'sd4480,
        -18'sd4608
    };

    function automatic logic signed [BEAR_W-1:0] thr_q8(input logic [POS_W-1:0] idx);
        logic signed [BEAR_W-1:0] t;
        t = THR_FLOOR;
        if (idx < POS_W'(TABLE_LEN))
        begin
            t = THR_Q8[idx];
        end
        return t;
    endfunction

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] a;
        case (idx)
            5'd0:    a = 22'd2949120;
            5'd1:    a = 22'd1740967;
            5'd2:    a = 22'd919879;
            5'd3:    a = 22'd466945;
            5'd4:    a = 22'd234379;
            5'd5:    a = 22'd117304;
            5'd6:    a = 22'd58666;
            5'd7:    a = 22'd29335;
            5'd8:    a = 22'd14668;
            5'd9:    a = 22'd7334;
            5'd10:   a = 22'd3667;
            5'd11:   a = 22'd1833;
            5'd12:   a = 22'd917;
            5'd13:   a = 22'd458;
            5'd14:   a = 22'd229;
            5'd15:   a = 22'd115;
            5'd16:   a = 22'd57;
            5'd17:   a = 22'd29;
            5'd18:   a = 22'd14;
            5'd19:   a = 22'd7;
            5'd20:   a = 22'd4;
            5'd21:   a = 22'd2;
            5'd22:   a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

### hw/rtl/pbsl_ctrl.sv
`timescale 1ns / 1ps

module pbsl_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  pbsl_pkg::stat_t stat,
    output pbsl_pkg::cmd_t  cmd
);

    pbsl_pkg::state_t state_reg;
    pbsl_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbsl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pbsl_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = stat.upd_now ? pbsl_pkg::ST_ROTATE : pbsl_pkg::ST_DONE;
                end
            end
            pbsl_pkg::ST_ROTATE:
            begin
                if (stat.rot_last)
                begin
                    state_next = pbsl_pkg::ST_BEARING;
                end
            end
            pbsl_pkg::ST_BEARING:
            begin
                state_next = pbsl_pkg::ST_SEARCH;
            end
            pbsl_pkg::ST_SEARCH:
            begin
                if (stat.srch_last)
                begin
                    state_next = pbsl_pkg::ST_DONE;
                end
            end
            pbsl_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = pbsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbsl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = (state_reg == pbsl_pkg::ST_IDLE);
        cmd.load       = (state_reg == pbsl_pkg::ST_IDLE) && s_tvalid;
        cmd.rotate     = (state_reg == pbsl_pkg::ST_ROTATE);
        cmd.bearing    = (state_reg == pbsl_pkg::ST_BEARING);
        cmd.search     = (state_reg == pbsl_pkg::ST_SEARCH);
        cmd.commit     = (state_reg == pbsl_pkg::ST_DONE) && (!out_valid_reg || m_tready);
        m_tvalid       = out_valid_reg;
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

endmodule

### hw/rtl/pbsl_datapath.sv
`timescale 1ns / 1ps

module pbsl_datapath
#(
    parameter int CORDIC_STEPS = pbsl_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pbsl_pkg::COUNT_W-1:0]        cfg_wdata,
    input  logic signed [pbsl_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [pbsl_pkg::COORD_BITS-1:0] point_y,
    input  logic [pbsl_pkg::COUNT_W-1:0]        point_count,
    input  pbsl_pkg::cmd_t                      cmd,
    output pbsl_pkg::stat_t                     stat,
    output logic signed [pbsl_pkg::LEVEL_W-1:0] steer_level,
    output logic                                updated
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int X_W    = pbsl_pkg::X_W;
    localparam int Z_W    = pbsl_pkg::Z_W;
    localparam int B_W    = pbsl_pkg::BEAR_W;
    localparam int P_W    = pbsl_pkg::POS_W;
    localparam int L_W    = pbsl_pkg::LEVEL_W;

    // control state
    logic [pbsl_pkg::COUNT_W-1:0] min_points_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [STEP_W-1:0]            step_next;
    logic [pbsl_pkg::BIT_W-1:0]   bit_reg;
    logic [pbsl_pkg::BIT_W-1:0]   bit_next;
    logic signed [L_W-1:0]        held_reg;
    logic signed [L_W-1:0]        held_next;

    // payload
    logic signed [X_W-1:0] x_reg;
    logic signed [X_W-1:0] x_next;
    logic signed [X_W-1:0] y_reg;
    logic signed [X_W-1:0] y_next;
    logic signed [Z_W-1:0] z_reg;
    logic signed [Z_W-1:0] z_next;
    logic                  zero_reg;
    logic                  zero_next;
    logic                  upd_reg;
    logic                  upd_next;
    logic signed [B_W-1:0] bear_reg;
    logic signed [B_W-1:0] bear_next;
    logic [P_W-1:0]        pos_reg;
    logic [P_W-1:0]        pos_next;
    logic signed [L_W-1:0] out_level_reg;
    logic signed [L_W-1:0] out_level_next;
    logic                  out_upd_reg;
    logic                  out_upd_next;

    logic signed [X_W-1:0] sx;
    logic signed [X_W-1:0] sy;
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;
    logic signed [Z_W-1:0] ang;
    logic signed [Z_W-1:0] z_rnd;
    logic [P_W-1:0]        cand;
    logic [P_W-1:0]        pos_clip;
    logic signed [L_W:0]   level_wide;
    logic signed [L_W-1:0] level_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_points_reg <= pbsl_pkg::MIN_POINTS_RST;
            step_reg       <= '0;
            bit_reg        <= '0;
            held_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_points_reg <= cfg_wdata;
            end
            step_reg <= step_next;
            bit_reg  <= bit_next;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        zero_reg      <= zero_next;
        upd_reg       <= upd_next;
        bear_reg      <= bear_next;
        pos_reg       <= pos_next;
        out_level_reg <= out_level_next;
        out_upd_reg   <= out_upd_next;
    end

    always_comb
    begin
        sx = {{(X_W - pbsl_pkg::COORD_BITS - pbsl_pkg::FRAC_SHIFT){point_x[pbsl_pkg::COORD_BITS-1]}},
              point_x, {pbsl_pkg::FRAC_SHIFT{1'b0}}};
        sy = {{(X_W - pbsl_pkg::COORD_BITS - pbsl_pkg::FRAC_SHIFT){point_y[pbsl_pkg::COORD_BITS-1]}},
              point_y, {pbsl_pkg::FRAC_SHIFT{1'b0}}};
        xs    = x_reg >>> step_reg;
        ys    = y_reg >>> step_reg;
        ang   = Z_W'(signed'({1'b0, pbsl_pkg::atan_q16(pbsl_pkg::ATAN_IDX_W'(step_reg))}));
        z_rnd = z_reg + pbsl_pkg::Z_ROUND;
        cand  = pos_reg | (P_W'(1) << bit_reg);
        pos_clip   = (pos_reg > pbsl_pkg::POS_MAX) ? pbsl_pkg::POS_MAX : pos_reg;
        level_wide = signed'({1'b0, pos_clip}) - pbsl_pkg::LEVEL_OFS;
        level_new  = level_wide[L_W-1:0];

        stat.upd_now   = (point_count >= min_points_reg);
        stat.rot_last  = (step_reg == STEP_W'(CORDIC_STEPS - 1));
        stat.srch_last = (bit_reg == '0);

        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zero_next      = zero_reg;
        upd_next       = upd_reg;
        bear_next      = bear_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        bit_next       = bit_reg;
        held_next      = held_reg;
        out_level_next = out_level_reg;
        out_upd_next   = out_upd_reg;

        if (cmd.load)
        begin
            upd_next  = stat.upd_now;
            zero_next = (point_x == '0) && (point_y == '0);
            step_next = '0;
            if (sx < 0)
            begin
                if (sy >= 0)
                begin
                    x_next = sy;
                    y_next = -sx;
                    z_next = pbsl_pkg::Z_QUARTER;
                end
                else
                begin
                    x_next = -sy;
                    y_next = sx;
                    z_next = -pbsl_pkg::Z_QUARTER;
                end
            end
            else
            begin
                x_next = sx;
                y_next = sy;
                z_next = '0;
            end
        end

        if (cmd.rotate)
        begin
            step_next = step_reg + 1'b1;
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
        end

        if (cmd.bearing)
        begin
            bear_next = zero_reg ? '0 : z_rnd[Z_W-1:Z_W-B_W];
            pos_next  = '0;
            bit_next  = pbsl_pkg::BIT_W'(pbsl_pkg::SRCH_STEPS - 1);
        end

        // successive approximation over the descending thresholds
        if (cmd.search)
        begin
            if (pbsl_pkg::thr_q8(cand - 1'b1) > bear_reg)
            begin
                pos_next = cand;
            end
            if (bit_reg != '0)
            begin
                bit_next = bit_reg - 1'b1;
            end
        end

        if (cmd.commit)
        begin
            out_upd_next = upd_reg;
            if (upd_reg)
            begin
                held_next      = level_new;
                out_level_next = level_new;
            end
            else
            begin
                out_level_next = held_reg;
            end
        end

        steer_level = out_level_reg;
        updated     = out_upd_reg;
    end

endmodule

### hw/rtl/point_bearing_to_steering_level.sv
`timescale 1ns / 1ps

// Turns the last point of a guide line into a steering level from -50 to +50.
// Each input transfer carries point_x, point_y (signed Q7.8) and point_count;
// when point_count is at least min_points, an iterative CORDIC computes
// atan2(point_y, point_x) in 1/256 degree and a 7-step binary search through
// a 101-entry threshold table picks the new level, which is held and sent with
// updated set. Otherwise the held level goes out with updated clear. Exactly
// one output transfer per input transfer, in order. One item is worked at a
// time: an updating item runs CORDIC_STEPS rotations through the one shared
// CORDIC add/shift stage and one table compare per search step; a non-updating
// item skips both. The finished result sits in an output register, so the next
// item is taken while it waits. min_points resets to 4 and is written through
// cfg_we/cfg_wdata.

module point_bearing_to_steering_level
#(
    parameter int CORDIC_STEPS = pbsl_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pbsl_pkg::COUNT_W-1:0]         cfg_wdata,   // min_points
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pbsl_pkg::S_TDATA_W-1:0]       s_tdata,     // point_x, point_y, point_count
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pbsl_pkg::M_TDATA_W-1:0]       m_tdata,     // steer_level
    output logic                                 m_tuser      // updated
);

    pbsl_pkg::cmd_t                      cmd;
    pbsl_pkg::stat_t                     stat;
    logic signed [pbsl_pkg::LEVEL_W-1:0] steer_level;
    logic                                updated;

    pbsl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pbsl_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .point_x     (s_tdata[15:0]),
        .point_y     (s_tdata[31:16]),
        .point_count (s_tdata[41:32]),
        .cmd         (cmd),
        .stat        (stat),
        .steer_level (steer_level),
        .updated     (updated)
    );

    assign m_tdata = {1'b0, steer_level};
    assign m_tuser = updated;

endmodule

### hw/rtl/pbsl_checker.sv
`timescale 1ns / 1ps

module pbsl_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] m_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic       m_tuser
);

    // stalled result holds
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    // level stays within the table range, pad bit clear
    a_level_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[7] && ($signed(m_tdata[6:0]) >= -7'sd50)
                     && ($signed(m_tdata[6:0]) <= 7'sd50))
        else $error("steering level out of range");

    // one item in flight: no acceptance right after a transfer in
    a_one_item : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

endmodule

bind point_bearing_to_steering_level pbsl_checker u_pbsl_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser)
);
